// ===== rtl/core/wpv_pkg.sv =====
// wpv_pkg: shared types and constants for the word packet validator
// parse phases, error codes, header geometry and the result record
// no dependencies
package wpv_pkg;

	localparam int HEADER_BYTES = 12;

	// byte counter width and its saturation value
	localparam int CNT_W = 17;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] HDR_MIN = CNT_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] HDR_LAST_POS = CNT_W'(HEADER_BYTES - 1);

	localparam logic [15:0] MAX_SIZE_RST = 16'd16384;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_LEN    = 3'd1,
		PH_BODY   = 3'd2,
		PH_TERM   = 3'd3,
		PH_DONE   = 3'd4,
		PH_HALT   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_LENGTH     = 3'd1,
		ERR_SIZE       = 3'd2,
		ERR_WORD_LONG  = 3'd3,
		ERR_ZERO_BYTE  = 3'd4,
		ERR_NO_TERM    = 3'd5,
		ERR_TRUNCATED  = 3'd6,
		ERR_TRAILING   = 3'd7
	} err_t;

	// one input byte as it travels through the input register
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} beat_t;

	// one packet verdict
	typedef struct packed {
		logic        valid_res;
		err_t        error_code;
		logic [31:0] header_word;
		logic [31:0] word_count;
	} result_t;

endpackage

// ===== rtl/core/wpv_in_if.sv =====
// wpv_in_if: byte request channel into the validator
// valid/ready handshake with one packet byte and its last-byte mark
// no dependencies
interface wpv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ===== rtl/core/wpv_out_if.sv =====
// wpv_out_if: verdict request channel out of the validator
// valid/ready handshake with the packet result fields
// no dependencies
interface wpv_out_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [2:0]  error_code;
	logic [31:0] header_word;
	logic [31:0] word_count;

	modport source (output valid, output valid_res, output error_code,
		output header_word, output word_count, input ready);
	modport sink (input valid, input valid_res, input error_code,
		input header_word, input word_count, output ready);
endinterface

// ===== rtl/core/wpv_in_stage.sv =====
// wpv_in_stage: input register for incoming byte requests
// depends on wpv_pkg and wpv_in_if
module wpv_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	wpv_in_if.sink         in_req,
	input  logic           advance,
	output logic           valid_s1,
	output wpv_pkg::beat_t beat_s1
);
	import wpv_pkg::*;

	// register is free when empty or draining this cycle
	assign in_req.ready = !valid_s1 || advance;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_req.ready) begin
			valid_s1 <= in_req.valid;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (in_req.valid && in_req.ready) begin
			beat_s1.data_byte <= in_req.data_byte;
			beat_s1.last      <= in_req.last;
		end
	end
endmodule

// ===== rtl/core/wpv_parser.sv =====
// wpv_parser: framing state machine, one byte per step
// keeps the per-packet counters and forms the verdict on the last byte
// depends on wpv_pkg
module wpv_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  wpv_pkg::beat_t   beat,
	input  logic [15:0]      max_size,
	output wpv_pkg::result_t res
);
	import wpv_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [31:0]      decl_q, decl_d;
	logic [31:0]      wexp_q, wexp_d;
	logic [31:0]      fin_q, fin_d;
	logic [31:0]      acc_q, acc_d;
	logic [1:0]       idx_q, idx_d;
	logic [31:0]      left_q, left_d;
	logic [31:0]      seq_q, seq_d;
	phase_t           phase_q, phase_d;
	err_t             err_q, err_d;
	logic             len_done;

	// next state for one byte
	always_comb begin
		logic [31:0] len;
		logic [1:0]  lane;
		len      = 32'd0;
		lane     = cnt_q[1:0];
		cnt_d    = (cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		decl_d   = decl_q;
		wexp_d   = wexp_q;
		fin_d    = fin_q;
		acc_d    = acc_q;
		idx_d    = idx_q;
		left_d   = left_q;
		seq_d    = seq_q;
		phase_d  = phase_q;
		err_d    = err_q;
		len_done = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				// header byte goes to its lane of the field it belongs to
				unique case (cnt_q[3:2])
					2'd0: seq_d[{lane, 3'b000} +: 8] = seq_q[{lane, 3'b000} +: 8] | beat.data_byte;
					2'd1: decl_d[{lane, 3'b000} +: 8] = decl_q[{lane, 3'b000} +: 8] | beat.data_byte;
					default: wexp_d[{lane, 3'b000} +: 8] = wexp_q[{lane, 3'b000} +: 8] | beat.data_byte;
				endcase
				if (cnt_q >= HDR_LAST_POS) begin
					phase_d = (wexp_d == 32'd0) ? PH_DONE : PH_LEN;
				end
			end
			PH_LEN: begin
				acc_d[{idx_q, 3'b000} +: 8] = acc_q[{idx_q, 3'b000} +: 8] | beat.data_byte;
				idx_d = idx_q + 2'd1;
				if (idx_d == 2'd0) begin
					len      = acc_d;
					acc_d    = 32'd0;
					len_done = 1'b1;
					// length check only when more bytes follow
					if (!beat.last && (len > decl_q)) begin
						err_d   = ERR_WORD_LONG;
						phase_d = PH_HALT;
					end else begin
						left_d  = len;
						phase_d = (len != 32'd0) ? PH_BODY : PH_TERM;
					end
				end
			end
			PH_BODY: begin
				if (beat.data_byte == 8'd0) begin
					err_d   = ERR_ZERO_BYTE;
					phase_d = PH_HALT;
				end else begin
					left_d = left_q - 32'd1;
					if (left_d == 32'd0) begin
						phase_d = PH_TERM;
					end
				end
			end
			PH_TERM: begin
				if (beat.data_byte != 8'd0) begin
					err_d   = ERR_NO_TERM;
					phase_d = PH_HALT;
				end else begin
					fin_d   = fin_q + 32'd1;
					phase_d = (fin_d == wexp_q) ? PH_DONE : PH_LEN;
				end
			end
			PH_DONE: begin
				err_d   = ERR_TRAILING;
				phase_d = PH_HALT;
			end
			PH_HALT: begin
				// only counting until the last byte
			end
			default: begin
			end
		endcase
	end

	// verdict from the updated state, in check order
	always_comb begin
		err_t code;
		priority if ((cnt_d < HDR_MIN) || (cnt_d > {1'b0, max_size})) begin
			code = ERR_LENGTH;
		end else if (decl_d != {{(32 - CNT_W){1'b0}}, cnt_d}) begin
			code = ERR_SIZE;
		end else if (err_d != ERR_NONE) begin
			code = err_d;
		end else if (phase_d == PH_DONE) begin
			code = ERR_NONE;
		end else if ((phase_d == PH_TERM) && !len_done) begin
			code = ERR_NO_TERM;
		end else begin
			code = ERR_TRUNCATED;
		end
		res.valid_res   = (code == ERR_NONE);
		res.error_code  = code;
		res.header_word = seq_d;
		res.word_count  = wexp_d;
	end

	// state update, cleared after the last byte of a packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			decl_q  <= '0;
			wexp_q  <= '0;
			fin_q   <= '0;
			acc_q   <= '0;
			idx_q   <= '0;
			left_q  <= '0;
			seq_q   <= '0;
			phase_q <= PH_HEADER;
			err_q   <= ERR_NONE;
		end else if (step) begin
			if (beat.last) begin
				cnt_q   <= '0;
				decl_q  <= '0;
				wexp_q  <= '0;
				fin_q   <= '0;
				acc_q   <= '0;
				idx_q   <= '0;
				left_q  <= '0;
				seq_q   <= '0;
				phase_q <= PH_HEADER;
				err_q   <= ERR_NONE;
			end else begin
				cnt_q   <= cnt_d;
				decl_q  <= decl_d;
				wexp_q  <= wexp_d;
				fin_q   <= fin_d;
				acc_q   <= acc_d;
				idx_q   <= idx_d;
				left_q  <= left_d;
				seq_q   <= seq_d;
				phase_q <= phase_d;
				err_q   <= err_d;
			end
		end
	end
endmodule

// ===== rtl/core/wpv_out_stage.sv =====
// wpv_out_stage: result register driving the verdict request channel
// depends on wpv_pkg and wpv_out_if
module wpv_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  wpv_pkg::result_t res,
	output logic             can_load,
	wpv_out_if.source        out_res
);
	import wpv_pkg::*;

	logic    valid_q;
	result_t res_q;

	// free when empty or being taken this cycle
	assign can_load = !valid_q || out_res.ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res;
		end
	end

	assign out_res.valid       = valid_q;
	assign out_res.valid_res   = res_q.valid_res;
	assign out_res.error_code  = res_q.error_code;
	assign out_res.header_word = res_q.header_word;
	assign out_res.word_count  = res_q.word_count;
endmodule

// ===== rtl/core/word_packet_validator.sv =====
// word_packet_validator: packet framing check over wpv_pkg, wpv_in_if and wpv_out_if
// throughput: one byte per cycle, set by the single-pass parser step; a last
//   byte waits only while the previous verdict has not been taken
// verdict path: a last byte passes the input register, then the parser step
//   into the result register, which drives the verdict channel
// reset: arst_n clears packet state, empties both registers, max_packet_size 16384
module word_packet_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	wpv_in_if.sink      in_req,
	wpv_out_if.source   out_res
);
	import wpv_pkg::*;

	logic        valid_s1;
	beat_t       beat_s1;
	logic        advance;
	logic        can_load;
	result_t     res;
	logic [15:0] max_size_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= MAX_SIZE_RST;
		end else if (cfg_we) begin
			max_size_q <= cfg_wdata;
		end
	end

	// a byte moves on unless its verdict has nowhere to go
	assign advance = valid_s1 && (!beat_s1.last || can_load);

	wpv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_req   (in_req),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	wpv_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.beat     (beat_s1),
		.max_size (max_size_q),
		.res      (res)
	);

	wpv_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && beat_s1.last),
		.res      (res),
		.can_load (can_load),
		.out_res  (out_res)
	);
endmodule

// ===== sim/word_packet_validator_checker.sv =====
`timescale 1ns / 1ps
// word_packet_validator_checker: watches the byte and verdict channels, tracks
// the packet framing of the validator and compares every verdict in order
// depends on wpv_pkg, wpv_in_if and wpv_out_if
module word_packet_validator_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	wpv_in_if           in_mon,
	wpv_out_if          out_mon,
	output int          fail_count,
	output int          pending,
	output int          verdicts,
	output logic [7:0]  codes_seen
);

	import wpv_pkg::*;

	// tracked copy of the register and of the packet parser
	logic [15:0]  max_size;
	logic [16:0]  nbytes;
	logic [31:0]  decl_size;
	logic [31:0]  words_exp;
	logic [31:0]  words_done;
	logic [31:0]  len_acc;
	logic [1:0]   len_idx;
	logic [31:0]  body_left;
	logic [31:0]  seq_word;
	phase_t       phase;
	err_t         first_err;
	result_t      verdict_q[$];

	function automatic void clear_packet();
		nbytes = '0;
		decl_size = '0;
		words_exp = '0;
		words_done = '0;
		len_acc = '0;
		len_idx = '0;
		body_left = '0;
		phase = PH_HEADER;
		first_err = ERR_NONE;
		seq_word = '0;
	endfunction

	function automatic void stop_on(input err_t e);
		first_err = e;
		phase = PH_HALT;
	endfunction

	// advance the framing state by one byte; the last byte queues a verdict
	function automatic void track_byte(input logic [7:0] b, input logic lst);
		logic [16:0] pos;
		logic [31:0] len;
		logic        len_done;
		err_t        code;
		result_t     r;
		pos = nbytes;
		len_done = 1'b0;
		if (nbytes != COUNT_MAX)
			nbytes = nbytes + 17'd1;

		case (phase)
			PH_HEADER: begin
				if (pos < 17'd4)
					seq_word |= {24'd0, b} << (8 * pos[1:0]);
				else if (pos < 17'd8)
					decl_size |= {24'd0, b} << (8 * pos[1:0]);
				else
					words_exp |= {24'd0, b} << (8 * pos[1:0]);
				if (pos >= HDR_LAST_POS)
					phase = (words_exp == 32'd0) ? PH_DONE : PH_LEN;
			end
			PH_LEN: begin
				len_acc |= {24'd0, b} << (8 * len_idx);
				len_idx = len_idx + 2'd1;
				if (len_idx == 2'd0) begin
					len = len_acc;
					len_acc = '0;
					len_done = 1'b1;
					// oversized length only counts when more bytes follow
					if (!lst && len > decl_size) begin
						stop_on(ERR_WORD_LONG);
					end else begin
						body_left = len;
						phase = (len != 32'd0) ? PH_BODY : PH_TERM;
					end
				end
			end
			PH_BODY: begin
				if (b == 8'd0) begin
					stop_on(ERR_ZERO_BYTE);
				end else begin
					body_left = body_left - 32'd1;
					if (body_left == 32'd0)
						phase = PH_TERM;
				end
			end
			PH_TERM: begin
				if (b != 8'd0) begin
					stop_on(ERR_NO_TERM);
				end else begin
					words_done = words_done + 32'd1;
					phase = (words_done == words_exp) ? PH_DONE : PH_LEN;
				end
			end
			PH_DONE: begin
				stop_on(ERR_TRAILING);
			end
			default: begin
			end
		endcase

		if (lst) begin
			// verdict priority: length, declared size, word errors, completeness
			if (nbytes < HDR_MIN || nbytes > {1'b0, max_size})
				code = ERR_LENGTH;
			else if (decl_size != {15'd0, nbytes})
				code = ERR_SIZE;
			else if (first_err != ERR_NONE)
				code = first_err;
			else if (phase == PH_DONE)
				code = ERR_NONE;
			else if (phase == PH_TERM && !len_done)
				code = ERR_NO_TERM;
			else
				code = ERR_TRUNCATED;
			r.valid_res = (code == ERR_NONE);
			r.error_code = code;
			r.header_word = seq_word;
			r.word_count = words_exp;
			verdict_q.insert(verdict_q.size(), r);
			clear_packet();
		end
	endfunction

	// compare verdicts, follow register writes, then feed accepted bytes
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			max_size = MAX_SIZE_RST;
			clear_packet();
			verdict_q.delete();
			fail_count <= 0;
			pending <= 0;
			verdicts <= 0;
			codes_seen <= '0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: verdict with none expected: valid=%0b code=%0d hdr=%h cnt=%h",
						$time, out_mon.valid_res, out_mon.error_code,
						out_mon.header_word, out_mon.word_count);
					fail_count <= fail_count + 1;
				end else begin
					want = verdict_q.pop_front();
					verdicts <= verdicts + 1;
					codes_seen[want.error_code] <= 1'b1;
					if (out_mon.valid_res !== want.valid_res ||
						out_mon.error_code !== want.error_code ||
						out_mon.header_word !== want.header_word ||
						out_mon.word_count !== want.word_count) begin
						$display("%0t: verdict mismatch: expected valid=%0b code=%0d hdr=%h cnt=%h",
							$time, want.valid_res, want.error_code,
							want.header_word, want.word_count);
						$display("%0t:                   actual valid=%0b code=%0d hdr=%h cnt=%h",
							$time, out_mon.valid_res, out_mon.error_code,
							out_mon.header_word, out_mon.word_count);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we)
				max_size = cfg_wdata;
			if (in_mon.valid && in_mon.ready)
				track_byte(in_mon.data_byte, in_mon.last);
			pending <= verdict_q.size();
		end
	end

endmodule

// ===== sim/word_packet_validator_tb.sv =====
`timescale 1ns / 1ps
// word_packet_validator_tb: drives framed, damaged and random packets into the
// validator under several size limits and flow-control patterns
// depends on wpv_pkg, wpv_in_if, wpv_out_if and word_packet_validator_checker
module word_packet_validator_tb;

	localparam int CYCLE_LIMIT = 500000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	wpv_in_if  in_req ();
	wpv_out_if out_res ();

	int          fail_count;
	int          pending;
	int          verdicts;
	logic [7:0]  codes_seen;

	int          send_idle_pct;
	int          recv_idle_pct;
	int          bytes_sent;
	int          packets_sent;
	int          cycle_cnt;
	logic [15:0] mid_limit;

	// packet under construction and where its fields sit
	logic [7:0]  pkt[$];
	int          len_pos[$];
	int          body_pos[$];
	int          term_pos[$];

	word_packet_validator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_req    (in_req),
		.out_res   (out_res)
	);

	word_packet_validator_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_mon     (in_req),
		.out_mon    (out_res),
		.fail_count (fail_count),
		.pending    (pending),
		.verdicts   (verdicts),
		.codes_seen (codes_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding", cycle_cnt, pending);
			$display("word_packet_validator test failed");
			$finish;
		end
	end

	// verdict side back-pressure
	initial begin
		out_res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// append one byte to the packet
	function automatic void add_byte(input logic [7:0] b);
		pkt.insert(pkt.size(), b);
	endfunction

	function automatic void put_word32(input logic [31:0] v);
		for (int k = 0; k < 4; k++)
			add_byte(v[8*k +: 8]);
	endfunction

	// patch a little-endian field, only the bytes the packet really has
	function automatic void set_word32(input int at, input logic [31:0] v);
		for (int k = 0; k < 4; k++)
			if (at + k < pkt.size())
				pkt[at + k] = v[8*k +: 8];
	endfunction

	function automatic void cut_to(input int n);
		while (pkt.size() > n)
			void'(pkt.pop_back());
	endfunction

	// well-formed packet with word lengths drawn from minlen..maxlen
	function automatic void build_framed(input logic [31:0] seq, input int nwords,
		input int minlen, input int maxlen);
		int len;
		pkt.delete();
		len_pos.delete();
		body_pos.delete();
		term_pos.delete();
		put_word32(seq);
		put_word32(32'd0);
		put_word32(nwords);
		for (int w = 0; w < nwords; w++) begin
			len = $urandom_range(maxlen, minlen);
			len_pos.insert(len_pos.size(), pkt.size());
			put_word32(len);
			repeat (len) begin
				body_pos.insert(body_pos.size(), pkt.size());
				add_byte(8'($urandom_range(255, 1)));
			end
			term_pos.insert(term_pos.size(), pkt.size());
			add_byte(8'h00);
		end
		set_word32(4, pkt.size());
	endfunction

	// good frames in 45 of 100 picks, the rest damaged in one way each or plain noise
	function automatic void random_packet();
		int pick;
		int at;
		pick = $urandom_range(99);
		if (pick < 45) begin
			build_framed($urandom, $urandom_range(4), 0, 8);
		end else if (pick < 52) begin
			// declared size off
			build_framed($urandom, $urandom_range(4), 0, 8);
			set_word32(4, pkt.size() ^ ($urandom | 32'h1));
		end else if (pick < 60) begin
			// zero byte inside a word
			build_framed($urandom, $urandom_range(4, 1), 1, 8);
			pkt[body_pos[$urandom_range(body_pos.size() - 1)]] = 8'h00;
		end else if (pick < 67) begin
			// nonzero where a terminator belongs
			build_framed($urandom, $urandom_range(4, 1), 0, 8);
			pkt[term_pos[$urandom_range(term_pos.size() - 1)]] = 8'($urandom_range(255, 1));
		end else if (pick < 74) begin
			// word length beyond the declared size
			build_framed($urandom, $urandom_range(4, 1), 0, 8);
			at = len_pos[$urandom_range(len_pos.size() - 1)];
			if ($urandom_range(1))
				set_word32(at, pkt.size() + $urandom_range(40, 1));
			else
				set_word32(at, $urandom | 32'h8000_0000);
		end else if (pick < 82) begin
			// bytes after the last word
			build_framed($urandom, $urandom_range(3), 0, 6);
			repeat ($urandom_range(4, 1))
				add_byte(8'($urandom));
			set_word32(4, pkt.size());
		end else if (pick < 92) begin
			// packet ends early, size field matches the cut length
			build_framed($urandom, $urandom_range(4, 1), 0, 8);
			cut_to($urandom_range(pkt.size() - 1, 12));
			set_word32(4, pkt.size());
		end else begin
			// raw noise, sometimes with a matching size field
			pkt.delete();
			repeat ($urandom_range(30, 1))
				add_byte(8'($urandom));
			if ($urandom_range(1))
				set_word32(4, pkt.size());
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_req.valid <= 1'b0;
			@(posedge clk);
		end
		in_req.valid <= 1'b1;
		in_req.data_byte <= b;
		in_req.last <= lst;
		@(posedge clk);
		while (!in_req.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
		packets_sent++;
	endtask

	// drain: all verdicts back, then room for the pipeline to empty
	task automatic settle();
		in_req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max(input logic [15:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_block(input int nbytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < nbytes) begin
			random_packet();
			send_packet();
		end
	endtask

	task automatic directed_packets();
		// minimal frame, no words, all-ones sequence word
		build_framed(32'hFFFF_FFFF, 0, 0, 0);
		send_packet();
		// three words, zero sequence word
		build_framed(32'h0, 3, 0, 6);
		send_packet();
		// two empty words
		build_framed($urandom, 2, 0, 0);
		send_packet();
		// one byte short of a header
		build_framed(32'hA5C3_0F81, 0, 0, 0);
		cut_to(11);
		send_packet();
		// single byte
		pkt.delete();
		add_byte(8'hFF);
		send_packet();
		// declared size all ones
		build_framed($urandom, 1, 1, 4);
		set_word32(4, 32'hFFFF_FFFF);
		send_packet();
		// word length all ones with bytes after it
		build_framed($urandom, 2, 1, 4);
		set_word32(len_pos[0], 32'hFFFF_FFFF);
		send_packet();
		// packet ends on an oversized length field
		build_framed($urandom, 1, 1, 4);
		cut_to(16);
		set_word32(12, 32'hFFFF_FFFF);
		set_word32(4, pkt.size());
		send_packet();
		// ends right after a zero length field
		build_framed($urandom, 1, 0, 0);
		cut_to(16);
		set_word32(4, pkt.size());
		send_packet();
		// ends inside a length field
		build_framed($urandom, 1, 2, 4);
		cut_to(14);
		set_word32(4, pkt.size());
		send_packet();
		// ends inside a word body
		build_framed($urandom, 1, 3, 5);
		cut_to(18);
		set_word32(4, pkt.size());
		send_packet();
		// ends right after a word body
		build_framed($urandom, 1, 3, 3);
		cut_to(19);
		set_word32(4, pkt.size());
		send_packet();
		// zero byte inside a word
		build_framed($urandom, 1, 4, 4);
		pkt[body_pos[2]] = 8'h00;
		send_packet();
		// terminator replaced by a data byte
		build_framed($urandom, 2, 2, 2);
		pkt[term_pos[0]] = 8'hFF;
		send_packet();
		// extra byte after the last word
		build_framed($urandom, 1, 1, 3);
		add_byte(8'h00);
		set_word32(4, pkt.size());
		send_packet();
		// word count far above the words sent
		build_framed($urandom, 1, 1, 3);
		set_word32(8, 32'hFFFF_FFFF);
		send_packet();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_req.valid <= 1'b0;
		in_req.data_byte <= '0;
		in_req.last <= 1'b0;
		cycle_cnt <= 0;
		bytes_sent = 0;
		packets_sent = 0;
		send_idle_pct = 11;
		recv_idle_pct = 85;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default limit, slow receiver
		directed_packets();
		random_block(480);

		// widest limit, slow sender
		write_max(16'hFFFF);
		send_idle_pct = 85;
		recv_idle_pct = 11;
		random_block(480);

		// limit at exactly one header, full rate from here on
		write_max(16'd12);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		build_framed($urandom, 0, 0, 0);
		send_packet();
		add_byte(8'h00);
		set_word32(4, pkt.size());
		send_packet();

		// limit below any valid packet
		write_max(16'd0);
		build_framed($urandom, 0, 0, 0);
		send_packet();
		random_packet();
		send_packet();

		// mid-range limit, some random packets overrun it
		mid_limit = 16'($urandom_range(200, 40));
		write_max(mid_limit);
		random_block(480);

		settle();
		repeat (10) @(posedge clk);
		$display("sent %0d packets (%0d bytes) under limits 16384, 65535, 12, 0 and %0d",
			packets_sent, bytes_sent, mid_limit);
		$display("%0d verdicts checked, error codes seen (bit per code) %b",
			verdicts, codes_seen);
		if (fail_count == 0)
			$display("word_packet_validator test passed");
		else
			$display("word_packet_validator test failed");
		$finish;
	end

endmodule
